[rtl/hrr_pkg.sv]
// ----------------------------------------------------------------------------
// Hue range remap package
// Shared types, register indexes, reset values and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package hrr_pkg;

    localparam int HUE_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FROM_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FROM_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TO_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TO_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_HUE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_SAT   = 3'd7;

    localparam logic [1:0] GRAY_NONE  = 2'd0;
    localparam logic [1:0] GRAY_SLICE = 2'd1;
    localparam logic [1:0] GRAY_TO    = 2'd2;
    // The fourth mode value is unused and behaves like GRAY_NONE.
    localparam logic [1:0] GRAY_RSVD  = 2'd3;

    localparam logic [12:0] FROM_START_RST = 13'd0;
    localparam logic [12:0] FROM_END_RST   = 13'd4095;
    localparam logic [12:0] TO_START_RST   = 13'd0;
    localparam logic [12:0] TO_END_RST     = 13'd4095;

    localparam int CHECKER_PERIOD_DEF = 20;
    localparam logic [7:0] CHECK_DARK  = 8'd102;
    localparam logic [7:0] CHECK_LIGHT = 8'd153;

    typedef struct packed {
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
        logic [7:0]  select_weight;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pix_out_t;

    // One pixel in HSV form, with what the blend and composite still need.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [7:0]       sat;
        logic [7:0]       val;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [7:0]       weight;
        logic             dark;
    } hsv_item_t;

    // Exact floor(x / 255) for any 16-bit x below 65280, by reciprocal multiplication.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] prod;
        prod = x * 17'd32897;
        return prod[30:23];
    endfunction

endpackage

[rtl/hrr_if.sv]
// ----------------------------------------------------------------------------
// Hue range remap stream interfaces
// Valid/ready channels for input pixels and rendered pixels.
// ----------------------------------------------------------------------------
interface hrr_pix_in_if;
    logic             valid;
    logic             ready;
    hrr_pkg::pix_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hrr_pix_out_if;
    logic              valid;
    logic              ready;
    hrr_pkg::pix_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hrr_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module hrr_div #(
    parameter int NW = 23,
    parameter int DW = 11,
    parameter int QW = 12,
    parameter type side_t = logic
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  side_t         side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output side_t         side_out
);

    logic [DW-1:0] rem_reg  [1:QW];
    logic [DW-1:0] rem_next [1:QW];
    logic [QW-1:0] low_reg  [1:QW];
    logic [QW-1:0] low_next [1:QW];
    logic [QW-1:0] quo_reg  [1:QW];
    logic [QW-1:0] quo_next [1:QW];
    logic [DW-1:0] dsr_reg  [1:QW];
    side_t         side_reg [1:QW];
    logic [QW:1]   valid_reg;

    genvar i;
    for (i = 1; i <= QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] dsr_prev;
        logic [QW-1:0] low_prev;
        logic [QW-1:0] quo_prev;
        side_t         side_prev;
        logic          valid_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (i == 1)
        begin : g_first
            // The upper dividend bits are below the divisor by construction.
            assign rem_prev   = DW'(dividend[NW-1:QW]);
            assign low_prev   = dividend[QW-1:0];
            assign quo_prev   = '0;
            assign dsr_prev   = divisor;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev   = rem_reg[i-1];
            assign low_prev   = low_reg[i-1];
            assign quo_prev   = quo_reg[i-1];
            assign dsr_prev   = dsr_reg[i-1];
            assign side_prev  = side_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        assign trial       = {rem_prev, low_prev[QW-1]};
        assign diff        = trial - {1'b0, dsr_prev};
        assign take        = (trial >= {1'b0, dsr_prev});
        assign rem_next[i] = take ? diff[DW-1:0] : trial[DW-1:0];
        assign low_next[i] = {low_prev[QW-2:0], 1'b0};
        assign quo_next[i] = {quo_prev[QW-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                quo_reg[i]  <= quo_next[i];
                dsr_reg[i]  <= dsr_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = quo_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

[rtl/hrr_rgb_out.sv]
// ----------------------------------------------------------------------------
// Hue range remap color back end
// HSV to RGB, blend with the original by weight, composite over the checker.
// ----------------------------------------------------------------------------
module hrr_rgb_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  hrr_pkg::hsv_item_t item,
    output logic               out_valid,
    output hrr_pkg::pix_out_t  pixel
);

    localparam logic [19:0] FULL_SCALE = 20'd1044480;
    localparam logic [27:0] HALF_SCALE = 28'd522240;

    logic [6:0] valid_reg;

    // Stage 1: sector, fraction and first products.
    hrr_pkg::hsv_item_t s1_item_reg;
    logic [2:0]  s1_sec_reg;
    logic [19:0] s1_sf_reg;
    logic [19:0] s1_sfc_reg;
    logic [15:0] s1_vs_reg;
    logic [14:0] h6;
    logic [11:0] frac;
    logic [12:0] frac_c;

    assign h6     = 15'(item.hue) * 15'd6;
    assign frac   = h6[11:0];
    assign frac_c = 13'd4096 - {1'b0, frac};

    // Stage 2: scaled q, t and p numerators.
    hrr_pkg::hsv_item_t s2_item_reg;
    logic [2:0]  s2_sec_reg;
    logic [15:0] s2_qn_reg;
    logic [15:0] s2_tn_reg;
    logic [15:0] s2_pn_reg;
    logic [27:0] xq;
    logic [27:0] xt;

    assign xq = s1_item_reg.val * (FULL_SCALE - s1_sf_reg) + HALF_SCALE;
    assign xt = s1_item_reg.val * (FULL_SCALE - s1_sfc_reg) + HALF_SCALE;

    // Stage 3: new color.
    hrr_pkg::hsv_item_t s3_item_reg;
    logic [7:0] s3_nr_reg, s3_ng_reg, s3_nb_reg;
    logic [7:0] pv, qv, tv;
    logic [7:0] nr, ng, nb;

    assign pv = hrr_pkg::div255(s2_pn_reg);
    assign qv = hrr_pkg::div255(s2_qn_reg);
    assign tv = hrr_pkg::div255(s2_tn_reg);

    always_comb
    begin
        case (s2_sec_reg)
            3'd0:    begin nr = s2_item_reg.val; ng = tv; nb = pv; end
            3'd1:    begin nr = qv; ng = s2_item_reg.val; nb = pv; end
            3'd2:    begin nr = pv; ng = s2_item_reg.val; nb = tv; end
            3'd3:    begin nr = pv; ng = qv; nb = s2_item_reg.val; end
            3'd4:    begin nr = tv; ng = pv; nb = s2_item_reg.val; end
            default: begin nr = s2_item_reg.val; ng = pv; nb = qv; end
        endcase
    end

    // Stage 4: blend numerators.
    hrr_pkg::hsv_item_t s4_item_reg;
    logic [15:0] s4_br_reg, s4_bg_reg, s4_bb_reg;
    logic [7:0]  inv_w;

    assign inv_w = 8'd255 - s3_item_reg.weight;

    // Stage 5: blended color.
    hrr_pkg::hsv_item_t s5_item_reg;
    logic [7:0] s5_cr_reg, s5_cg_reg, s5_cb_reg;

    // Stage 6: composite numerators.
    logic [15:0] s6_ar_reg, s6_ag_reg, s6_ab_reg;
    logic [7:0]  inv_a;
    logic [7:0]  bg;

    assign inv_a = 8'd255 - s5_item_reg.alpha;
    assign bg    = s5_item_reg.dark ? hrr_pkg::CHECK_DARK : hrr_pkg::CHECK_LIGHT;

    // Stage 7: result.
    hrr_pkg::pix_out_t s7_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item;
            s1_sec_reg  <= h6[14:12];
            s1_sf_reg   <= 20'(item.sat * frac);
            s1_sfc_reg  <= 20'(item.sat * frac_c);
            s1_vs_reg   <= 16'(item.val * (8'd255 - item.sat));

            s2_item_reg <= s1_item_reg;
            s2_sec_reg  <= s1_sec_reg;
            s2_qn_reg   <= xq[27:12];
            s2_tn_reg   <= xt[27:12];
            s2_pn_reg   <= s1_vs_reg + 16'd127;

            s3_item_reg <= s2_item_reg;
            s3_nr_reg   <= nr;
            s3_ng_reg   <= ng;
            s3_nb_reg   <= nb;

            s4_item_reg <= s3_item_reg;
            s4_br_reg   <= 16'(inv_w * s3_item_reg.red)
                           + 16'(s3_item_reg.weight * s3_nr_reg) + 16'd127;
            s4_bg_reg   <= 16'(inv_w * s3_item_reg.green)
                           + 16'(s3_item_reg.weight * s3_ng_reg) + 16'd127;
            s4_bb_reg   <= 16'(inv_w * s3_item_reg.blue)
                           + 16'(s3_item_reg.weight * s3_nb_reg) + 16'd127;

            s5_item_reg <= s4_item_reg;
            s5_cr_reg   <= hrr_pkg::div255(s4_br_reg);
            s5_cg_reg   <= hrr_pkg::div255(s4_bg_reg);
            s5_cb_reg   <= hrr_pkg::div255(s4_bb_reg);

            s6_ar_reg   <= 16'(s5_item_reg.alpha * s5_cr_reg) + 16'(inv_a * bg) + 16'd127;
            s6_ag_reg   <= 16'(s5_item_reg.alpha * s5_cg_reg) + 16'(inv_a * bg) + 16'd127;
            s6_ab_reg   <= 16'(s5_item_reg.alpha * s5_cb_reg) + 16'(inv_a * bg) + 16'd127;

            s7_pix_reg.out_red   <= hrr_pkg::div255(s6_ar_reg);
            s7_pix_reg.out_green <= hrr_pkg::div255(s6_ag_reg);
            s7_pix_reg.out_blue  <= hrr_pkg::div255(s6_ab_reg);
        end
    end

    assign out_valid = valid_reg[6];
    assign pixel     = s7_pix_reg;

endmodule

[rtl/hue_range_remap_pixel.sv]
// Throughput: one pixel per clock while the skid slot is empty; the hue,
// saturation and mapping dividers are fully pipelined, one quotient bit per
// stage, so nothing iterates. A stalled output parks one pixel in a skid
// register and the whole pipeline holds until it drains. Reset clears all
// valid bits and loads the register defaults; pixel data registers are not
// reset.
// ----------------------------------------------------------------------------
// Hue range remap, top level
// RGB to HSV, gray handling, hue range mapping and output skid buffer.
// ----------------------------------------------------------------------------
module hue_range_remap_pixel #(
    parameter int CHECKER_PERIOD = hrr_pkg::CHECKER_PERIOD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrr_pkg::CFG_W-1:0]      cfg_data,
    hrr_pix_in_if.sink                     pix_in,
    hrr_pix_out_if.source                  pix_out
);

    localparam int          CK_SHIFT = 24;
    localparam logic [24:0] CK_MUL   = 25'((2**CK_SHIFT + CHECKER_PERIOD - 1) / CHECKER_PERIOD);
    localparam logic [11:0] CK_P     = 12'(CHECKER_PERIOD);
    localparam logic [11:0] CK_HALF  = 12'(CHECKER_PERIOD / 2);

    typedef struct packed {
        hrr_pkg::pix_in_t pix;
        logic [11:0]      qrow;
        logic [11:0]      qcol;
        logic             mx_zero;
    } front_t;

    typedef struct packed {
        hrr_pkg::hsv_item_t item;
        logic               domap;
        logic               equal;
        logic signed [13:0] to_diff;
        logic signed [14:0] xoff;
        logic [12:0]        den;
    } map_b_t;

    typedef struct packed {
        hrr_pkg::hsv_item_t item;
        logic               domap;
        logic               equal;
        logic signed [28:0] num;
        logic [12:0]        den;
    } map_c_t;

    typedef struct packed {
        hrr_pkg::hsv_item_t item;
        logic               domap;
        logic               equal;
        logic               neg;
    } map_d_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] from_start_reg, from_end_reg, to_start_reg, to_end_reg;
    logic [7:0]  gray_thr_reg, gray_sat_reg;
    logic [1:0]  gray_mode_reg;
    logic [11:0] gray_hue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_start_reg <= hrr_pkg::FROM_START_RST;
            from_end_reg   <= hrr_pkg::FROM_END_RST;
            to_start_reg   <= hrr_pkg::TO_START_RST;
            to_end_reg     <= hrr_pkg::TO_END_RST;
            gray_thr_reg   <= '0;
            gray_mode_reg  <= hrr_pkg::GRAY_NONE;
            gray_hue_reg   <= '0;
            gray_sat_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hrr_pkg::REG_FROM_START: from_start_reg <= cfg_data;
                hrr_pkg::REG_FROM_END:   from_end_reg   <= cfg_data;
                hrr_pkg::REG_TO_START:   to_start_reg   <= cfg_data;
                hrr_pkg::REG_TO_END:     to_end_reg     <= cfg_data;
                hrr_pkg::REG_GRAY_THR:   gray_thr_reg   <= cfg_data[7:0];
                hrr_pkg::REG_GRAY_MODE:  gray_mode_reg  <= cfg_data[1:0];
                hrr_pkg::REG_GRAY_HUE:   gray_hue_reg   <= cfg_data[11:0];
                hrr_pkg::REG_GRAY_SAT:   gray_sat_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [12:0] range_lo, range_hi;
    assign range_lo = (from_start_reg < from_end_reg) ? from_start_reg : from_end_reg;
    assign range_hi = (from_start_reg < from_end_reg) ? from_end_reg : from_start_reg;

    // Returns {inside, unwrapped position}.
    function automatic logic [14:0] src_pos(input logic [11:0] x,
                                            input logic [12:0] lo,
                                            input logic [12:0] hi);
        logic [13:0] xa;
        logic [13:0] xb;
        xa = {2'b00, x};
        xb = xa + 14'd4096;
        if ({1'b0, lo} <= xa && xa <= {1'b0, hi})
            return {1'b1, xa};
        else if ({1'b0, lo} <= xb && xb <= {1'b0, hi})
            return {1'b1, xb};
        else
            return '0;
    endfunction

    function automatic logic [7:0] st_max(input hrr_pkg::pix_in_t p);
        logic [7:0] m;
        m = p.in_red;
        if (p.in_green > m) m = p.in_green;
        if (p.in_blue > m) m = p.in_blue;
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: whole pipeline advances unless the skid slot is full.
    // ------------------------------------------------------------------
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;
    hrr_pkg::pix_out_t skid_pix_reg, out_pix_reg;

    assign adv          = !skid_valid_reg;
    assign pix_in.ready = adv;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic             st0_valid_reg;
    hrr_pkg::pix_in_t st0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st0_valid_reg <= 1'b0;
        else if (adv)
            st0_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            st0_pix_reg <= pix_in.data;
    end

    // ------------------------------------------------------------------
    // Front: max, min, hue sector numerator, divider operands
    // ------------------------------------------------------------------
    logic [7:0]  r0, g0, b0, mx, mn, dl;
    logic [10:0] hnum;
    logic [36:0] prow, pcol;

    assign r0 = st0_pix_reg.in_red;
    assign g0 = st0_pix_reg.in_green;
    assign b0 = st0_pix_reg.in_blue;

    always_comb
    begin
        mx = r0;
        if (g0 > mx) mx = g0;
        if (b0 > mx) mx = b0;
        mn = r0;
        if (g0 < mn) mn = g0;
        if (b0 < mn) mn = b0;
    end

    assign dl = mx - mn;

    always_comb
    begin
        if (mx == r0)
            hnum = (g0 >= b0) ? 11'(g0 - b0) : 11'(11'd6 * dl) - 11'(b0 - g0);
        else if (mx == g0)
            hnum = 11'(11'd2 * dl) + 11'(b0) - 11'(r0);
        else
            hnum = 11'(11'd4 * dl) + 11'(r0) - 11'(g0);
    end

    assign prow = st0_pix_reg.pixel_row * CK_MUL;
    assign pcol = st0_pix_reg.pixel_column * CK_MUL;

    logic        st1_valid_reg;
    front_t      st1_front_reg;
    logic [19:0] st1_snum_reg;
    logic [7:0]  st1_sden_reg;
    logic [22:0] st1_hnum_reg;
    logic [10:0] st1_hden_reg;
    logic        st1_dzero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st1_valid_reg <= 1'b0;
        else if (adv)
            st1_valid_reg <= st0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_front_reg.pix     <= st0_pix_reg;
            st1_front_reg.qrow    <= prow[CK_SHIFT +: 12];
            st1_front_reg.qcol    <= pcol[CK_SHIFT +: 12];
            st1_front_reg.mx_zero <= (mx == 8'd0);
            st1_snum_reg          <= 20'(16'(dl * 8'd255) + 16'(mx >> 1));
            st1_sden_reg          <= mx;
            st1_hnum_reg          <= {hnum, 12'd0} + 23'(dl * 10'd3);
            st1_hden_reg          <= 11'(dl * 11'd6);
            st1_dzero_reg         <= (dl == 8'd0);
        end
    end

    // ------------------------------------------------------------------
    // Saturation and hue dividers, in lockstep
    // ------------------------------------------------------------------
    logic        sdiv_valid, hdiv_valid;
    logic [11:0] sdiv_q, hdiv_q;
    front_t      sdiv_front;
    logic        hdiv_dzero;

    hrr_div #(.NW(20), .DW(8), .QW(12), .side_t(front_t)) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (st1_valid_reg),
        .dividend  (st1_snum_reg),
        .divisor   (st1_sden_reg),
        .side_in   (st1_front_reg),
        .out_valid (sdiv_valid),
        .quotient  (sdiv_q),
        .side_out  (sdiv_front)
    );

    hrr_div #(.NW(23), .DW(11), .QW(12), .side_t(logic)) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (st1_valid_reg),
        .dividend  (st1_hnum_reg),
        .divisor   (st1_hden_reg),
        .side_in   (st1_dzero_reg),
        .out_valid (hdiv_valid),
        .quotient  (hdiv_q),
        .side_out  (hdiv_dzero)
    );

    // ------------------------------------------------------------------
    // Stage A: HSV pixel and checker square
    // ------------------------------------------------------------------
    logic [11:0] rrow, rcol;
    logic        dark;

    assign rrow = sdiv_front.pix.pixel_row - 12'(sdiv_front.qrow * CK_P);
    assign rcol = sdiv_front.pix.pixel_column - 12'(sdiv_front.qcol * CK_P);
    assign dark = (rrow > CK_HALF && rcol > CK_HALF) || (rrow < CK_HALF && rcol < CK_HALF);

    logic               sta_valid_reg;
    hrr_pkg::hsv_item_t sta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sta_valid_reg <= 1'b0;
        else if (adv)
            sta_valid_reg <= sdiv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sta_reg.hue    <= hdiv_dzero ? 12'd0 : hdiv_q;
            sta_reg.sat    <= sdiv_front.mx_zero ? 8'd0 : sdiv_q[7:0];
            sta_reg.val    <= 8'(st_max(sdiv_front.pix));
            sta_reg.red    <= sdiv_front.pix.in_red;
            sta_reg.green  <= sdiv_front.pix.in_green;
            sta_reg.blue   <= sdiv_front.pix.in_blue;
            sta_reg.alpha  <= sdiv_front.pix.in_alpha;
            sta_reg.weight <= sdiv_front.pix.select_weight;
            sta_reg.dark   <= dark;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: gray handling and range membership
    // ------------------------------------------------------------------
    logic        is_gray;
    logic [14:0] hue_in, gray_in;
    logic [13:0] pos;
    logic        domap;
    map_b_t      b_next;

    assign is_gray = (sta_reg.sat <= gray_thr_reg) && (sta_reg.weight != 8'd0);
    assign hue_in  = src_pos(sta_reg.hue, range_lo, range_hi);
    assign gray_in = src_pos(gray_hue_reg, range_lo, range_hi);

    always_comb
    begin
        b_next.item = sta_reg;
        pos         = hue_in[13:0];
        domap       = hue_in[14];
        if (is_gray && gray_mode_reg == hrr_pkg::GRAY_SLICE)
        begin
            if (gray_in[14])
            begin
                b_next.item.hue = gray_hue_reg;
                b_next.item.sat = gray_sat_reg;
                pos             = gray_in[13:0];
            end
            else
            begin
                // Gray hue outside the source slice: the pixel keeps its original color.
                b_next.item.weight = 8'd0;
            end
            domap = gray_in[14];
        end
        else if (is_gray && gray_mode_reg == hrr_pkg::GRAY_TO)
        begin
            b_next.item.hue = gray_hue_reg;
            b_next.item.sat = gray_sat_reg;
            domap           = 1'b0;
        end
        b_next.domap   = domap;
        b_next.equal   = (from_start_reg == from_end_reg);
        b_next.to_diff = $signed({1'b0, to_end_reg}) - $signed({1'b0, to_start_reg});
        b_next.xoff    = (from_end_reg < from_start_reg)
                         ? $signed({2'b00, from_start_reg}) - $signed({1'b0, pos})
                         : $signed({1'b0, pos}) - $signed({2'b00, from_start_reg});
        b_next.den     = range_hi - range_lo;
    end

    logic   stb_valid_reg;
    map_b_t stb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stb_valid_reg <= 1'b0;
        else if (adv)
            stb_valid_reg <= sta_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stb_reg <= b_next;
    end

    // ------------------------------------------------------------------
    // Stage C: mapping product
    // ------------------------------------------------------------------
    logic   stc_valid_reg;
    map_c_t stc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stc_valid_reg <= 1'b0;
        else if (adv)
            stc_valid_reg <= stb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stc_reg.item  <= stb_reg.item;
            stc_reg.domap <= stb_reg.domap;
            stc_reg.equal <= stb_reg.equal;
            stc_reg.num   <= stb_reg.to_diff * stb_reg.xoff;
            stc_reg.den   <= stb_reg.den;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: rounding numerator, folded to a non-negative dividend
    // ------------------------------------------------------------------
    logic signed [29:0] rnum;
    logic [27:0]        mdiv_num;
    logic [13:0]        mdiv_den;
    map_d_t             d_next;

    assign rnum     = $signed({stc_reg.num, 1'b0}) + $signed({17'd0, stc_reg.den});
    assign mdiv_den = {stc_reg.den, 1'b0};

    // A negative numerator divides its ceiling, so the floor comes back on negation.
    always_comb
    begin
        d_next.item  = stc_reg.item;
        d_next.domap = stc_reg.domap;
        d_next.equal = stc_reg.equal;
        d_next.neg   = rnum[29];
        if (rnum[29])
            mdiv_num = 28'(-rnum + $signed({16'd0, mdiv_den}) - 30'sd1);
        else
            mdiv_num = 28'(rnum);
    end

    logic        std_valid_reg;
    map_d_t      std_reg;
    logic [27:0] std_num_reg;
    logic [13:0] std_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            std_valid_reg <= 1'b0;
        else if (adv)
            std_valid_reg <= stc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            std_reg     <= d_next;
            std_num_reg <= mdiv_num;
            std_den_reg <= mdiv_den;
        end
    end

    logic        mdiv_valid;
    logic [13:0] mdiv_q;
    map_d_t      mdiv_side;

    hrr_div #(.NW(28), .DW(14), .QW(14), .side_t(map_d_t)) u_map_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (std_valid_reg),
        .dividend  (std_num_reg),
        .divisor   (std_den_reg),
        .side_in   (std_reg),
        .out_valid (mdiv_valid),
        .quotient  (mdiv_q),
        .side_out  (mdiv_side)
    );

    // ------------------------------------------------------------------
    // Stage E: target hue, clamped and wrapped to one turn
    // ------------------------------------------------------------------
    logic signed [15:0] qs, ymap;
    hrr_pkg::hsv_item_t e_next;

    assign qs = mdiv_side.neg ? -$signed({2'b00, mdiv_q}) : $signed({2'b00, mdiv_q});

    always_comb
    begin
        ymap = $signed({3'b000, to_start_reg}) + qs;
        if (mdiv_side.equal)
            ymap = $signed({3'b000, to_start_reg});
        if (ymap < 0)
            ymap = '0;
        e_next = mdiv_side.item;
        if (mdiv_side.domap)
            e_next.hue = ymap[11:0];
    end

    logic               ste_valid_reg;
    hrr_pkg::hsv_item_t ste_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ste_valid_reg <= 1'b0;
        else if (adv)
            ste_valid_reg <= mdiv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ste_reg <= e_next;
    end

    // ------------------------------------------------------------------
    // Color back end
    // ------------------------------------------------------------------
    logic              rgb_valid;
    hrr_pkg::pix_out_t rgb_pix;

    hrr_rgb_out u_rgb_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ste_valid_reg),
        .item      (ste_reg),
        .out_valid (rgb_valid),
        .pixel     (rgb_pix)
    );

    // ------------------------------------------------------------------
    // Output register and skid slot
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pix_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= rgb_valid;
            end
        end
        else if (!skid_valid_reg && rgb_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pix_out.ready)
        begin
            out_pix_reg <= skid_valid_reg ? skid_pix_reg : rgb_pix;
        end
        else if (!skid_valid_reg)
        begin
            skid_pix_reg <= rgb_pix;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_pix_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        sdiv_valid == hdiv_valid)
        else $error("saturation and hue dividers out of step");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pix_out.ready))
        else $error("skid slot filled while output was free");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a pixel with an empty output register");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pix_out.ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid slot did not drain into the output register");

endmodule

[tb/tb_hue_range_remap_pixel.sv]
// ----------------------------------------------------------------------------
// Hue range remap pixel testbench
// Drives pixel requests through valid/ready channels under several register
// settings, predicts every rendered pixel and compares it field by field.
// ----------------------------------------------------------------------------
module tb_hue_range_remap_pixel;

    localparam int PERIOD = 20;
    localparam int TURN   = 4096;
    localparam int LATENCY = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [hrr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hrr_pkg::CFG_W-1:0] cfg_data;

    hrr_pix_in_if  pix_in ();
    hrr_pix_out_if pix_out ();

    hue_range_remap_pixel #(.CHECKER_PERIOD(PERIOD)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in.sink),
        .pix_out   (pix_out.source)
    );

    // Register copy used by the predictor.
    int unsigned src_start, src_end, dst_start, dst_end;
    int unsigned gray_thr, gray_md, gray_h, gray_s;

    hrr_pkg::pix_out_t expected_pixels[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;

    typedef struct {
        hrr_pkg::pix_in_t  px;
        bit                known;
        hrr_pkg::pix_out_t res;
    } stim_row_t;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("tb_hue_range_remap_pixel failed");
        $finish;
    end

    function automatic bit hue_in_source(input int unsigned x, output longint pos);
        longint lo, hi, v;
        lo = (src_start < src_end) ? src_start : src_end;
        hi = (src_start < src_end) ? src_end : src_start;
        v = x;
        pos = v;
        if (lo <= v && v <= hi)
            return 1'b1;
        v += TURN;
        pos = v;
        return (lo <= v && v <= hi);
    endfunction

    function automatic int unsigned remap_hue(input int unsigned x);
        longint xs, num, den, y, n2, d2, q;
        if (!hue_in_source(x, xs))
            return x;
        if (src_start == src_end)
            y = dst_start;
        else
        begin
            num = (longint'(dst_end) - longint'(dst_start)) * (xs - longint'(src_start));
            den = longint'(src_end) - longint'(src_start);
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            n2 = 2 * num + den;
            d2 = 2 * den;
            q = n2 / d2;
            if ((n2 % d2) != 0 && n2 < 0)
                q--;
            y = longint'(dst_start) + q;
        end
        if (y < 0)
            y = 0;
        return int'(y) & (TURN - 1);
    endfunction

    function automatic void hsv_to_rgb(input int unsigned h, input int unsigned s,
                                       input int unsigned v, output int unsigned c[3]);
        int unsigned h6, sec, f, den, p, q, t;
        h6 = (h & (TURN - 1)) * 6;
        sec = h6 >> 12;
        f = h6 & (TURN - 1);
        den = 255 * TURN;
        p = (v * (255 - s) + 127) / 255;
        q = (v * (den - s * f) + den / 2) / den;
        t = (v * (den - s * (TURN - f)) + den / 2) / den;
        case (sec)
            0: c = '{v, t, p};
            1: c = '{q, v, p};
            2: c = '{p, v, t};
            3: c = '{p, q, v};
            4: c = '{t, p, v};
            default: c = '{v, p, q};
        endcase
    endfunction

    function automatic hrr_pkg::pix_out_t render_pixel(input hrr_pkg::pix_in_t px);
        int unsigned orig[3], c[3], h, s, v, mx, mn, d, num, m, a, bg, cc;
        int ra, ca;
        bit keep, skip;
        longint pos;
        hrr_pkg::pix_out_t res;
        orig = '{px.in_red, px.in_green, px.in_blue};
        a = px.in_alpha;
        m = px.select_weight;
        ra = int'(px.pixel_row % PERIOD) - PERIOD / 2;
        ca = int'(px.pixel_column % PERIOD) - PERIOD / 2;
        bg = (ra * ca > 0) ? hrr_pkg::CHECK_DARK : hrr_pkg::CHECK_LIGHT;
        mx = orig[0];
        mn = orig[0];
        for (int k = 1; k < 3; k++)
        begin
            if (orig[k] > mx) mx = orig[k];
            if (orig[k] < mn) mn = orig[k];
        end
        d = mx - mn;
        v = mx;
        s = (mx == 0) ? 0 : (d * 255 + mx / 2) / mx;
        h = 0;
        if (d != 0)
        begin
            if (mx == orig[0])
                num = (orig[1] >= orig[2]) ? orig[1] - orig[2] : 6 * d - (orig[2] - orig[1]);
            else if (mx == orig[1])
                num = 2 * d + orig[2] - orig[0];
            else
                num = 4 * d + orig[0] - orig[1];
            h = ((num * TURN + 3 * d) / (6 * d)) & (TURN - 1);
        end
        keep = 1'b0;
        skip = 1'b0;
        c = '{0, 0, 0};
        if (s <= gray_thr && m != 0)
        begin
            if (gray_md == hrr_pkg::GRAY_SLICE)
            begin
                if (hue_in_source(gray_h, pos))
                begin
                    h = gray_h;
                    s = gray_s;
                end
                else
                begin
                    skip = 1'b1;
                    keep = 1'b1;
                end
            end
            else if (gray_md == hrr_pkg::GRAY_TO)
            begin
                skip = 1'b1;
                hsv_to_rgb(gray_h, gray_s, v, c);
            end
        end
        if (!skip)
            hsv_to_rgb(remap_hue(h), s, v, c);
        if (keep)
            m = 0;
        for (int k = 0; k < 3; k++)
        begin
            cc = ((255 - m) * orig[k] + m * c[k] + 127) / 255;
            c[k] = (a * cc + (255 - a) * bg + 127) / 255;
        end
        res.out_red = c[0][7:0];
        res.out_green = c[1][7:0];
        res.out_blue = c[2][7:0];
        return res;
    endfunction

    task automatic write_reg(input logic [hrr_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[hrr_pkg::CFG_W-1:0];
        case (idx)
            hrr_pkg::REG_FROM_START: src_start = value & 13'h1fff;
            hrr_pkg::REG_FROM_END:   src_end = value & 13'h1fff;
            hrr_pkg::REG_TO_START:   dst_start = value & 13'h1fff;
            hrr_pkg::REG_TO_END:     dst_end = value & 13'h1fff;
            hrr_pkg::REG_GRAY_THR:   gray_thr = value & 8'hff;
            hrr_pkg::REG_GRAY_MODE:  gray_md = value & 2'h3;
            hrr_pkg::REG_GRAY_HUE:   gray_h = value & 12'hfff;
            hrr_pkg::REG_GRAY_SAT:   gray_s = value & 8'hff;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setting(input int unsigned fs, input int unsigned fe,
                                input int unsigned ts, input int unsigned te,
                                input int unsigned thr, input int unsigned md,
                                input int unsigned gh, input int unsigned gs);
        write_reg(hrr_pkg::REG_FROM_START, fs);
        write_reg(hrr_pkg::REG_FROM_END, fe);
        write_reg(hrr_pkg::REG_TO_START, ts);
        write_reg(hrr_pkg::REG_TO_END, te);
        write_reg(hrr_pkg::REG_GRAY_THR, thr);
        write_reg(hrr_pkg::REG_GRAY_MODE, md);
        write_reg(hrr_pkg::REG_GRAY_HUE, gh);
        write_reg(hrr_pkg::REG_GRAY_SAT, gs);
    endtask

    // Stops offering requests and waits until every pending pixel is out.
    task automatic drain;
        int guard;
        guard = 0;
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Sends one request and records its prediction once it is accepted.
    // Valid stays high afterwards so that requests can follow back to back.
    task automatic send_pixel(input hrr_pkg::pix_in_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= px;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        expected_pixels.push_back(render_pixel(px));
    endtask

    function automatic hrr_pkg::pix_in_t random_pixel(input bit grayish);
        hrr_pkg::pix_in_t px;
        px.in_red = 8'($urandom);
        px.in_green = 8'($urandom);
        px.in_blue = 8'($urandom);
        px.in_alpha = 8'($urandom);
        px.select_weight = 8'($urandom);
        px.pixel_row = 12'($urandom);
        px.pixel_column = 12'($urandom);
        if (grayish)
        begin
            px.in_green = px.in_red + 8'($urandom_range(2));
            px.in_blue = px.in_red;
        end
        case ($urandom_range(7))
            0: px.in_alpha = 8'd255;
            1: px.in_alpha = 8'd0;
            default: ;
        endcase
        case ($urandom_range(7))
            0: px.select_weight = 8'd0;
            1, 2: px.select_weight = 8'd255;
            default: ;
        endcase
        return px;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel($urandom_range(3) == 0));
    endtask

    // Receiver side: random stalls plus one long hold-off on request.
    initial begin
        pix_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (recv_hold)
            begin
                pix_out.ready <= 1'b0;
                for (int n = 0; n < 150; n++)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("rendered pixel with no request pending: %h", pix_out.data);
                errors++;
            end
            else
            begin
                hrr_pkg::pix_out_t want;
                want = expected_pixels.pop_front();
                if (pix_out.data.out_red !== want.out_red)
                begin
                    $error("out_red expected %0d actual %0d", want.out_red,
                           pix_out.data.out_red);
                    errors++;
                end
                if (pix_out.data.out_green !== want.out_green)
                begin
                    $error("out_green expected %0d actual %0d", want.out_green,
                           pix_out.data.out_green);
                    errors++;
                end
                if (pix_out.data.out_blue !== want.out_blue)
                begin
                    $error("out_blue expected %0d actual %0d", want.out_blue,
                           pix_out.data.out_blue);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        hrr_pkg::pix_out_t got;
        clk = 1'b0;
        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        recv_hold = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 75;
        src_start = hrr_pkg::FROM_START_RST;
        src_end = hrr_pkg::FROM_END_RST;
        dst_start = hrr_pkg::TO_START_RST;
        dst_end = hrr_pkg::TO_END_RST;
        gray_thr = 0;
        gray_md = hrr_pkg::GRAY_NONE;
        gray_h = 0;
        gray_s = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under reset registers: identity mapping.
        // Opaque black, white and red pixels and fully transparent ones have known results.
        rows = '{
            '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 12'd0, 12'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
            '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 12'd4095, 12'd4095}, 1'b1,
              '{8'd255, 8'd255, 8'd255}},
            '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 12'd5, 12'd5}, 1'b1,
              '{8'd102, 8'd102, 8'd102}},
            '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 12'd5, 12'd15}, 1'b1,
              '{8'd153, 8'd153, 8'd153}},
            '{'{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 12'd0, 12'd0}, 1'b1,
              '{8'd255, 8'd0, 8'd0}},
            '{'{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 12'd1, 12'd2}, 1'b0, '{0, 0, 0}},
            '{'{8'd0, 8'd0, 8'd255, 8'd200, 8'd255, 12'd2048, 12'd7}, 1'b0, '{0, 0, 0}},
            '{'{8'd255, 8'd0, 8'd255, 8'd1, 8'd1, 12'd10, 12'd10}, 1'b0, '{0, 0, 0}},
            '{'{8'd12, 8'd200, 8'd90, 8'd128, 8'd77, 12'd19, 12'd19}, 1'b0, '{0, 0, 0}}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known)
            begin
                got = render_pixel(r.px);
                if (got !== r.res)
                begin
                    $error("table row %0d: predictor gives %h, row gives %h", i, got, r.res);
                    errors++;
                end
            end
            send_pixel(r.px);
        end
        drain();

        // Gray mode from with the gray hue inside a wrapped range, first directly, then through the wrap.
        load_setting(3000, 5000, 8191, 100, 10, hrr_pkg::GRAY_SLICE, 3500, 200);
        send_pixel('{8'd90, 8'd90, 8'd90, 8'd255, 8'd255, 12'd3, 12'd3});
        send_pixel('{8'd90, 8'd90, 8'd90, 8'd255, 8'd0, 12'd3, 12'd3});
        send_pixel('{8'd255, 8'd0, 8'd20, 8'd255, 8'd255, 12'd3, 12'd3});
        drain();
        write_reg(hrr_pkg::REG_GRAY_HUE, 100);
        send_pixel('{8'd50, 8'd51, 8'd50, 8'd255, 8'd200, 12'd3, 12'd3});
        drain();
        // Gray mode to and the unused mode value.
        write_reg(hrr_pkg::REG_GRAY_MODE, hrr_pkg::GRAY_TO);
        send_pixel('{8'd50, 8'd51, 8'd50, 8'd180, 8'd255, 12'd3, 12'd30});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0});
        drain();
        write_reg(hrr_pkg::REG_GRAY_MODE, hrr_pkg::GRAY_RSVD);
        send_pixel('{8'd50, 8'd51, 8'd50, 8'd255, 8'd255, 12'd3, 12'd3});
        drain();
        // Source range of a single hue, reversed target range and extreme register values.
        load_setting(1365, 1365, 8191, 0, 255, hrr_pkg::GRAY_NONE, 4095, 255);
        send_pixel('{8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 12'd0, 12'd0});
        send_pixel('{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 12'd0, 12'd0});
        drain();

        load_setting(4000, 100, 0, 8191, 20, hrr_pkg::GRAY_SLICE, 50, 128);
        random_phase(130);
        drain();
        send_idle_pct = 75;
        recv_idle_pct = 21;
        load_setting(8191, 0, 2000, 6000, 255, hrr_pkg::GRAY_TO, 4095, 0);
        random_phase(130);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_setting($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(8191), $urandom_range(60), $urandom_range(2),
                     $urandom_range(4095), $urandom_range(255));
        recv_hold = 1'b1;
        random_phase(140);
        drain();

        if (errors == 0)
            $display("tb_hue_range_remap_pixel passed");
        else
            $display("tb_hue_range_remap_pixel failed");
        $finish;
    end
endmodule

[sim.f]
rtl/hrr_pkg.sv
rtl/hrr_if.sv
rtl/hrr_div.sv
rtl/hrr_rgb_out.sv
rtl/hue_range_remap_pixel.sv
tb/tb_hue_range_remap_pixel.sv
